[hdl/cluster_track_hit_ranking_defines.svh]
// Assertion macros shared by the cluster track hit ranking RTL.
`ifndef CLUSTER_TRACK_HIT_RANKING_DEFINES_SVH
`define CLUSTER_TRACK_HIT_RANKING_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define CTHR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define CTHR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/cthr_pkg.sv]
//------------------------------------------------------------------------------
// cthr_pkg
// Shared types and constants of the cluster track hit ranking block.
//------------------------------------------------------------------------------
`default_nettype none
package cthr_pkg;
	localparam int MaxTracks = 64;
	localparam int TopCount = 5;
	localparam int LayersPerModule = 6;
	localparam int IdxW = $clog2(MaxTracks);
	localparam int UsedW = $clog2(MaxTracks + 1);
	localparam int RankW = 3;
	localparam int IdW = 24;
	localparam int CntW = 8;
	localparam logic [CntW-1:0] CountMax = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_RANK,
		ST_EMIT,
		ST_CLEAR
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load_hit;
		logic scan_start;
		logic scan_step;
		logic update;
		logic rank_start;
		logic rank_step;
		logic emit_load;
		logic clear;
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic scan_done;
		logic last_id;
		logic rank_done;
		logic run_done;
		logic hit_last;
	} stat_t;
endpackage
`default_nettype wire

[hdl/cthr_datapath.sv]
//------------------------------------------------------------------------------
// cthr_datapath
// Track table, serial id match, serial ranking scan and output register.
//------------------------------------------------------------------------------
`default_nettype none
`include "cluster_track_hit_ranking_defines.svh"
module cthr_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cthr_pkg::cmd_t       cmd,
	output cthr_pkg::stat_t           stat,
	input  wire logic [3:0]           layer,
	input  wire logic [1:0]           time_flags,
	input  wire logic [23:0]          track_first,
	input  wire logic [23:0]          track_second,
	input  wire logic                 last_hit,
	output logic [2:0]                rank,
	output logic [23:0]               track_id,
	output logic [7:0]                hit_count,
	output logic [5:0]                layers_first_module,
	output logic [5:0]                layers_second_module,
	output logic [2:0]                tracks_reported,
	output logic                      table_overflow,
	output logic                      last_result
);
	import cthr_pkg::*;

	logic [IdW-1:0]  ids_q   [MaxTracks];
	logic [CntW-1:0] cnts_q  [MaxTracks];
	logic [5:0]      mfa_q   [MaxTracks];
	logic [5:0]      mfb_q   [MaxTracks];
	logic [MaxTracks-1:0] taken_q;

	logic [UsedW-1:0] used_q;
	logic             ovf_q;
	logic [IdW-1:0]   id_a_q, id_b_q;
	logic [1:0]       pend_q;
	logic             mod_q;
	logic [5:0]       bit_q;
	logic             last_q;
	logic [UsedW-1:0] scan_q;
	logic             found_q;
	logic [IdxW-1:0]  slot_q;
	logic [CntW-1:0]  slot_cnt_q;
	logic [5:0]       slot_mfa_q;
	logic [5:0]       slot_mfb_q;
	logic [IdxW-1:0]  best_q;
	logic             best_ok_q;
	logic [CntW-1:0]  best_cnt_q;
	logic [IdW-1:0]   best_id_q;
	logic [5:0]       best_mfa_q;
	logic [5:0]       best_mfb_q;
	logic [RankW-1:0] rank_q;
	logic [RankW-1:0] rep_q;

	logic [IdW-1:0]   rd_id_q;
	logic [CntW-1:0]  rd_cnt_q;
	logic [5:0]       rd_mfa_q;
	logic [5:0]       rd_mfb_q;
	logic             cmp_ok_s1;
	logic [IdxW-1:0]  cmp_idx_s1;

	logic [IdW-1:0] cur_id;
	logic [IdxW-1:0] scan_idx;
	logic [IdxW-1:0] best_idx;
	logic            cur_is_b;
	logic [UsedW-1:0] used_d;

	// The pending id is the first one still to be applied.
	assign cur_is_b = !pend_q[0];
	assign cur_id = cur_is_b ? id_b_q : id_a_q;
	assign scan_idx = scan_q[IdxW-1:0];
	assign best_idx = best_q;

	// Fill count as it stands after the update of this cycle.
	assign used_d = (cmd.update && pend_q != 2'b00 && !found_q &&
		used_q < UsedW'(MaxTracks)) ? used_q + 1'b1 : used_q;

	// Status toward the controller.
	always_comb begin
		stat.scan_done = found_q || ((scan_q >= used_q) && !cmp_ok_s1);
		stat.last_id   = (pend_q == 2'b01) || (pend_q == 2'b10) || (pend_q == 2'b00);
		stat.rank_done = (scan_q >= used_q) && !cmp_ok_s1;
		stat.run_done  = (rank_q + 1'b1 >= rep_q) || (rep_q == '0);
		stat.hit_last  = last_q;
	end

	// Control registers of the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			ovf_q <= 1'b0;
			pend_q <= '0;
			taken_q <= '0;
		end else begin
			if (cmd.load_hit) begin
				pend_q <= (layer < 4'(2 * LayersPerModule)) ? time_flags : 2'b00;
			end
			if (cmd.update && pend_q != 2'b00) begin
				if (found_q) begin
				end else if (used_q < UsedW'(MaxTracks)) begin
					used_q <= used_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
				if (!cur_is_b) pend_q[0] <= 1'b0;
				else pend_q[1] <= 1'b0;
			end
			if (cmd.rank_start) taken_q <= '0;
			if (cmd.emit_load && best_ok_q) taken_q[best_idx] <= 1'b1;
			if (cmd.clear) begin
				used_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	// Hit capture, id scan and ranking scan. The scan address is issued in the cycle
	// before its entry is compared, since the table is read through a register.
	always_ff @(posedge clk) begin
		if (cmd.load_hit) begin
			id_a_q <= track_first;
			id_b_q <= track_second;
			last_q <= last_hit;
			mod_q  <= (layer >= 4'(LayersPerModule));
			bit_q  <= 6'(1) << ((layer >= 4'(LayersPerModule)) ?
				layer - 4'(LayersPerModule) : layer);
			rank_q <= '0;
		end
		if (cmd.scan_start) begin
			scan_q <= '0;
			found_q <= 1'b0;
			cmp_ok_s1 <= 1'b0;
		end else if (cmd.scan_step) begin
			if (scan_q < used_q) scan_q <= scan_q + 1'b1;
			cmp_ok_s1 <= (scan_q < used_q);
			cmp_idx_s1 <= scan_idx;
			if (cmp_ok_s1 && rd_id_q == cur_id) begin
				found_q <= 1'b1;
				slot_q <= cmp_idx_s1;
				slot_cnt_q <= rd_cnt_q;
				slot_mfa_q <= rd_mfa_q;
				slot_mfb_q <= rd_mfb_q;
			end
		end
		if (cmd.rank_start) begin
			scan_q <= '0;
			cmp_ok_s1 <= 1'b0;
			best_ok_q <= 1'b0;
			best_q <= '0;
			rep_q <= (used_d > UsedW'(TopCount)) ? RankW'(TopCount) : RankW'(used_d);
		end else if (cmd.rank_step) begin
			if (scan_q < used_q) scan_q <= scan_q + 1'b1;
			cmp_ok_s1 <= (scan_q < used_q);
			cmp_idx_s1 <= scan_idx;
			if (cmp_ok_s1 && !taken_q[cmp_idx_s1] &&
				(!best_ok_q || rd_cnt_q > best_cnt_q)) begin
				best_q <= cmp_idx_s1;
				best_ok_q <= 1'b1;
				best_cnt_q <= rd_cnt_q;
				best_id_q <= rd_id_q;
				best_mfa_q <= rd_mfa_q;
				best_mfb_q <= rd_mfb_q;
			end
		end
		if (cmd.emit_load) begin
			scan_q <= '0;
			cmp_ok_s1 <= 1'b0;
			best_ok_q <= 1'b0;
			rank_q <= rank_q + 1'b1;
		end
	end

	// Table write: a hit either bumps the found entry or, while the table has room, opens a new one.
	// The table is read at the scan address into the read registers.
	always_ff @(posedge clk) begin
		rd_id_q  <= ids_q[scan_idx];
		rd_cnt_q <= cnts_q[scan_idx];
		rd_mfa_q <= mfa_q[scan_idx];
		rd_mfb_q <= mfb_q[scan_idx];
		if (cmd.update && pend_q != 2'b00) begin
			if (found_q) begin
				cnts_q[slot_q] <= (slot_cnt_q != CountMax) ? slot_cnt_q + 1'b1 : slot_cnt_q;
				if (mod_q) mfb_q[slot_q] <= slot_mfb_q | bit_q;
				else mfa_q[slot_q] <= slot_mfa_q | bit_q;
			end else if (used_q < UsedW'(MaxTracks)) begin
				ids_q[used_q[IdxW-1:0]]  <= cur_id;
				cnts_q[used_q[IdxW-1:0]] <= 8'd1;
				mfa_q[used_q[IdxW-1:0]]  <= mod_q ? 6'd0 : bit_q;
				mfb_q[used_q[IdxW-1:0]]  <= mod_q ? bit_q : 6'd0;
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			rank <= rank_q;
			tracks_reported <= rep_q;
			table_overflow <= ovf_q;
			last_result <= (rank_q + 1'b1 >= rep_q);
			if (best_ok_q && rep_q != '0) begin
				track_id <= best_id_q;
				hit_count <= best_cnt_q;
				layers_first_module <= best_mfa_q;
				layers_second_module <= best_mfb_q;
			end else begin
				track_id <= '0;
				hit_count <= '0;
				layers_first_module <= '0;
				layers_second_module <= '0;
			end
		end
	end

	`CTHR_ASSERT_IMP(a_used_bound, clk, arst_n, 1'b1, used_q <= UsedW'(MaxTracks), "table count beyond capacity")
	`CTHR_ASSERT_NEXT(a_clear_empties, clk, arst_n, cmd.clear, used_q == '0 && !ovf_q, "clear failed")
	`CTHR_ASSERT_IMP(a_rep_bound, clk, arst_n, cmd.emit_load, rep_q <= RankW'(TopCount), "report count too big")
endmodule
`default_nettype wire

[hdl/cthr_ctrl.sv]
//------------------------------------------------------------------------------
// cthr_ctrl
// Sequencer: id match and update per hit, then ranking and output per cluster.
//------------------------------------------------------------------------------
`default_nettype none
`include "cluster_track_hit_ranking_defines.svh"
module cthr_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic            out_stall,
	output logic                 out_valid,
	input  wire cthr_pkg::stat_t stat,
	output cthr_pkg::cmd_t       cmd
);
	import cthr_pkg::*;

	state_t state_q, state_d;
	logic   ov_q;
	logic   out_free;

	assign out_free = !ov_q || !out_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SCAN;
			ST_SCAN:   if (stat.scan_done) state_d = ST_UPDATE;
			ST_UPDATE: begin
				if (!stat.last_id) state_d = ST_SCAN;
				else if (stat.hit_last) state_d = ST_RANK;
				else state_d = ST_IDLE;
			end
			ST_RANK:   if (stat.rank_done) state_d = ST_EMIT;
			ST_EMIT:   if (out_free) state_d = stat.run_done ? ST_CLEAR : ST_RANK;
			ST_CLEAR:  state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Commands.
	always_comb begin
		cmd = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE:   begin
				cmd.load_hit = in_valid;
				cmd.scan_start = in_valid;
			end
			ST_SCAN:   cmd.scan_step = !stat.scan_done;
			ST_UPDATE: begin
				cmd.update = 1'b1;
				cmd.scan_start = !stat.last_id;
				cmd.rank_start = stat.last_id && stat.hit_last;
			end
			ST_RANK:   cmd.rank_step = !stat.rank_done;
			ST_EMIT:   cmd.emit_load = out_free;
			ST_CLEAR:  cmd.clear = 1'b1;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit_load) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	assign out_valid = ov_q;

	`CTHR_ASSERT_IMP(a_idle_only_take, clk, arst_n, cmd.load_hit, state_q == ST_IDLE, "hit taken while busy")
	`CTHR_ASSERT_NEXT(a_emit_valid, clk, arst_n, cmd.emit_load, ov_q, "emitted word not valid")
	`CTHR_ASSERT_IMP(a_emit_free, clk, arst_n, cmd.emit_load, !ov_q || !out_stall, "overwrite of stalled word")
endmodule
`default_nettype wire

[hdl/cluster_track_hit_ranking.sv]
// Sequence: a hit is taken in the idle state; then for each valid id (once if none) the table
// fill is scanned through a register, one entry per cycle, and the table is updated.
// A last hit adds per rank a scan plus an output load, which waits while the output stalls,
// and then a clear state. Only one hit is taken at a time; the input stalls until it is done.
// Reset: arst_n clears the sequencer, table fill count and overflow flag; table contents
// are left as they are and are never read before written.
//------------------------------------------------------------------------------
// cluster_track_hit_ranking
// Counts track ids over the hits of a cluster and ranks the top five on the last hit.
//------------------------------------------------------------------------------
`default_nettype none
module cluster_track_hit_ranking (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [3:0]  layer,
	input  wire logic [1:0]  time_flags,
	input  wire logic [23:0] track_first,
	input  wire logic [23:0] track_second,
	input  wire logic        last_hit,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       rank,
	output logic [23:0]      track_id,
	output logic [7:0]       hit_count,
	output logic [5:0]       layers_first_module,
	output logic [5:0]       layers_second_module,
	output logic [2:0]       tracks_reported,
	output logic             table_overflow,
	output logic             last_result
);
	import cthr_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequencer.
	cthr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_stall(out_stall), .out_valid(out_valid), .stat(stat), .cmd(cmd)
	);

	// Table and ranking datapath.
	cthr_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.layer(layer), .time_flags(time_flags), .track_first(track_first),
		.track_second(track_second), .last_hit(last_hit),
		.rank(rank), .track_id(track_id), .hit_count(hit_count),
		.layers_first_module(layers_first_module),
		.layers_second_module(layers_second_module),
		.tracks_reported(tracks_reported), .table_overflow(table_overflow),
		.last_result(last_result)
	);
endmodule
`default_nettype wire
